// ===== hw/rtl/eqc_pkg.sv =====
`timescale 1ns / 1ps

package eqc_pkg;

  localparam int FRAME_BYTES_DEF = 12;
  localparam int QUEUE_DEPTH     = 4;
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;

  localparam logic [7:0]  CMD_BYTE     = 8'h1A;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1000;
  localparam logic [15:0] INTERVAL_RST = 16'd200;
  localparam logic [16:0] OFFSET_RST   = 17'd7420;

  localparam logic signed [24:0] WRAP_SPAN = 25'sd131072;
  localparam logic signed [24:0] HALF_SPAN = 25'sd65536;

  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_OFFSET   = 2'd2;

  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_REQUEST = 2'd1;
  localparam logic [1:0] FUNC_BYTE    = 2'd2;
  localparam logic [1:0] FUNC_READ    = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } eqc_item_t;

  typedef struct packed {
    logic               accepted;
    logic               tx_valid;
    logic [7:0]         tx_byte;
    logic signed [23:0] angle;
    logic               frame_ready;
    logic               rx_busy;
    logic [31:0]        request_total;
    logic [31:0]        response_total;
    logic [31:0]        timeout_total;
    logic [31:0]        last_latency_us;
    logic [31:0]        max_latency_us;
  } eqc_result_t;

  typedef struct packed {
    logic [15:0] timeout_us;
    logic [15:0] interval_us;
    logic [16:0] angle_offset;
  } eqc_cfg_t;

  typedef struct packed {
    logic       tick;
    logic       request;
    logic       rx;
    logic       read;
    logic [7:0] rx_byte;
  } eqc_op_t;

endpackage

// ===== hw/rtl/eqc_chan_if.sv =====
`timescale 1ns / 1ps

interface eqc_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/eqc_regs.sv =====
`timescale 1ns / 1ps

module eqc_regs import eqc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output eqc_cfg_t          cfg
);

  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_us   <= TIMEOUT_RST;
      cfg.interval_us  <= INTERVAL_RST;
      cfg.angle_offset <= OFFSET_RST;
    end else if (wr_en) begin
      case (paddr[ADDR_W-1:2])
        REG_TIMEOUT: begin
          cfg.timeout_us <= pwdata[15:0];
        end
        REG_INTERVAL: begin
          cfg.interval_us <= pwdata[15:0];
        end
        REG_OFFSET: begin
          cfg.angle_offset <= pwdata[16:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[ADDR_W-1:2])
      REG_TIMEOUT: begin
        prdata = {16'd0, cfg.timeout_us};
      end
      REG_INTERVAL: begin
        prdata = {16'd0, cfg.interval_us};
      end
      REG_OFFSET: begin
        prdata = {15'd0, cfg.angle_offset};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/eqc_front.sv =====
`timescale 1ns / 1ps

module eqc_front import eqc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  eqc_chan_if.sink   req,
  output logic       push,
  output eqc_op_t    push_op,
  input  logic       full
);

  logic    vld;
  eqc_op_t op;
  eqc_op_t op_next;

  assign req.ready = !vld || !full;
  assign push      = vld && !full;
  assign push_op   = op;

  always_comb begin
    op_next         = '0;
    op_next.rx_byte = req.data.rx_byte;
    case (req.data.func)
      FUNC_TICK: begin
        op_next.tick = 1'b1;
      end
      FUNC_REQUEST: begin
        op_next.request = 1'b1;
      end
      FUNC_BYTE: begin
        op_next.rx = 1'b1;
      end
      FUNC_READ: begin
        op_next.read = 1'b1;
      end
      default: begin
        op_next.tick = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (req.ready) begin
      vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      op <= op_next;
    end
  end

endmodule

// ===== hw/rtl/eqc_fifo.sv =====
`timescale 1ns / 1ps

module eqc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: begin
          count <= count + 1'b1;
        end
        2'b01: begin
          count <= count - 1'b1;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ===== hw/rtl/eqc_back.sv =====
`timescale 1ns / 1ps

module eqc_back import eqc_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  eqc_cfg_t  cfg,
  input  logic      empty,
  input  eqc_op_t   op,
  output logic      pop,
  eqc_chan_if.source rsp
);

  localparam int IDX_W = $clog2(FRAME_BYTES);

  logic [31:0]      now_us;
  logic [31:0]      request_time;
  logic [31:0]      requests_sent;
  logic [31:0]      responses_seen;
  logic [31:0]      timeouts_seen;
  logic [31:0]      latency_last;
  logic [31:0]      latency_max;
  logic             busy;
  logic             ready_flag;
  logic [IDX_W-1:0] byte_index;
  logic [7:0]       frame_store [FRAME_BYTES];

  logic             out_vld;
  eqc_result_t      out_data;

  logic [31:0]      elapsed;
  logic             timed_out;
  logic             drop;
  logic             grant;
  logic             cap;
  logic             done;
  logic             read_hit;
  logic [22:0]      raw;
  logic signed [24:0] pos;
  logic signed [24:0] pos_wrap;

  logic [31:0]      now_next;
  logic [31:0]      requests_next;
  logic [31:0]      responses_next;
  logic [31:0]      timeouts_next;
  logic [31:0]      latency_last_next;
  logic [31:0]      latency_max_next;
  logic             busy_next;
  logic             ready_next;
  logic [IDX_W-1:0] byte_index_next;
  eqc_result_t      out_next;

  assign pop       = !empty && (!out_vld || rsp.ready);
  assign rsp.valid = out_vld;
  assign rsp.data  = out_data;

  assign elapsed   = now_us - request_time;
  assign timed_out = busy && (elapsed >= {16'd0, cfg.timeout_us});
  assign drop      = op.request && timed_out;
  assign grant     = op.request && !ready_flag && !(busy && !timed_out) &&
                     (elapsed >= {16'd0, cfg.interval_us});
  assign cap       = op.rx && busy;
  assign done      = cap && (byte_index == IDX_W'(FRAME_BYTES - 1));
  assign read_hit  = op.read && ready_flag;

  assign raw = {frame_store[5][6:0], frame_store[4], frame_store[3]};
  assign pos = $signed({2'b00, raw}) - $signed({8'd0, cfg.angle_offset});

  always_comb begin
    pos_wrap = pos;
    if (pos >= HALF_SPAN) begin
      pos_wrap = pos - WRAP_SPAN;
    end else if (pos < -HALF_SPAN) begin
      pos_wrap = pos + WRAP_SPAN;
    end
  end

  always_comb begin
    now_next          = now_us + {31'd0, op.tick};
    requests_next     = requests_sent + {31'd0, grant};
    timeouts_next     = timeouts_seen + {31'd0, drop};
    responses_next    = responses_seen + {31'd0, done};
    latency_last_next = done ? elapsed : latency_last;
    latency_max_next  = (done && (elapsed > latency_max)) ? elapsed : latency_max;

    busy_next = busy;
    if (grant) begin
      busy_next = 1'b1;
    end else if (drop || done) begin
      busy_next = 1'b0;
    end

    ready_next = ready_flag;
    if (done) begin
      ready_next = 1'b1;
    end else if (read_hit) begin
      ready_next = 1'b0;
    end

    byte_index_next = byte_index;
    if (grant || drop || done) begin
      byte_index_next = '0;
    end else if (cap) begin
      byte_index_next = byte_index + 1'b1;
    end

    out_next.accepted        = grant || read_hit;
    out_next.tx_valid        = grant;
    out_next.tx_byte         = grant ? CMD_BYTE : 8'd0;
    out_next.angle           = read_hit ? pos_wrap[23:0] : 24'sd0;
    out_next.frame_ready     = ready_next;
    out_next.rx_busy         = busy_next;
    out_next.request_total   = requests_next;
    out_next.response_total  = responses_next;
    out_next.timeout_total   = timeouts_next;
    out_next.last_latency_us = latency_last_next;
    out_next.max_latency_us  = latency_max_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_us         <= '0;
      request_time   <= '0;
      requests_sent  <= '0;
      responses_seen <= '0;
      timeouts_seen  <= '0;
      latency_last   <= '0;
      latency_max    <= '0;
      busy           <= 1'b0;
      ready_flag     <= 1'b0;
      byte_index     <= '0;
    end else if (pop) begin
      now_us         <= now_next;
      requests_sent  <= requests_next;
      responses_seen <= responses_next;
      timeouts_seen  <= timeouts_next;
      latency_last   <= latency_last_next;
      latency_max    <= latency_max_next;
      busy           <= busy_next;
      ready_flag     <= ready_next;
      byte_index     <= byte_index_next;
      if (grant) begin
        request_time <= now_us;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cap) begin
      frame_store[byte_index] <= op.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (pop) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= out_next;
    end
  end

endmodule

// ===== hw/rtl/encoder_query_controller_unit.sv =====
`timescale 1ns / 1ps

// Polling controller for a serial absolute encoder. Each word on req is one
// event (microsecond tick, request, received byte, position read) and yields
// exactly one word on rsp carrying the command byte to send, the decoded
// position and the running status and latency counters. A word is accepted
// every cycle while the queue has room; a result is registered once its word
// has moved from the front register through the event queue into the result
// register. The sustained rate of one word per cycle is set by the back end,
// which applies one event per cycle to the controller state while rsp is not
// stalled. Timeout, request interval and position offset sit at byte
// addresses 0, 4 and 8 of the APB port; the user must see that they are
// written only while no word is in flight, and the block does not enforce this.
module encoder_query_controller_unit import eqc_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  eqc_chan_if.sink          req,
  eqc_chan_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int OP_W = $bits(eqc_op_t);

  eqc_cfg_t        cfg;
  logic            push;
  eqc_op_t         push_op;
  logic            full;
  logic            empty;
  logic            pop;
  logic [OP_W-1:0] q_dout;
  eqc_op_t         q_op;

  assign q_op = q_dout;

  eqc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eqc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .push    (push),
    .push_op (push_op),
    .full    (full)
  );

  eqc_fifo #(
    .WIDTH (OP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_op),
    .pop   (pop),
    .dout  (q_dout),
    .full  (full),
    .empty (empty)
  );

  eqc_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .empty (empty),
    .op    (q_op),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule

// ===== hw/rtl/eqc_checker.sv =====
`timescale 1ns / 1ps

module eqc_checker import eqc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input eqc_result_t rsp_data
);

  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result word valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result word changed");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.tx_valid |->
      rsp_data.accepted && rsp_data.tx_byte == CMD_BYTE &&
      rsp_data.rx_busy && !rsp_data.frame_ready)
    else $error("granted request without busy capture");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_data.rx_busy && rsp_data.frame_ready))
    else $error("capture busy while frame pending");

endmodule

bind encoder_query_controller_unit eqc_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import eqc_pkg::*;

  localparam int FRAME_LEN = FRAME_BYTES_DEF;

  typedef struct {
    eqc_item_t   word;
    bit          pinned;
    eqc_result_t want;
  } stim_row_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  eqc_chan_if #(.payload_t(eqc_item_t))   req_if ();
  eqc_chan_if #(.payload_t(eqc_result_t)) rsp_if ();

  encoder_query_controller_unit dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // encoder controller shadow state
  logic [15:0] cfg_timeout;
  logic [15:0] cfg_interval;
  logic [16:0] cfg_offset;
  logic [31:0] now_ticks;
  logic [31:0] req_stamp;
  bit          capturing;
  bit          frame_held;
  int          byte_pos;
  logic [7:0]  frame_bytes [FRAME_LEN];
  logic [31:0] n_requests;
  logic [31:0] n_responses;
  logic [31:0] n_timeouts;
  logic [31:0] lat_last;
  logic [31:0] lat_peak;

  eqc_result_t status_due [$];
  int          mismatches;
  int          words_sent;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          stall_rsp;
  bit          pin_valid;
  eqc_result_t pin_value;
  stim_row_t   plan [$];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic advance_encoder(input eqc_item_t w, output eqc_result_t r);
    logic [31:0] elapsed;
    int pos;
    r = '0;
    elapsed = now_ticks - req_stamp;
    case (w.func)
      FUNC_TICK: begin
        now_ticks = now_ticks + 1;
      end
      FUNC_REQUEST: begin
        if (!frame_held) begin
          // drop a capture that has run past its timeout
          if (capturing && elapsed >= {16'd0, cfg_timeout}) begin
            capturing = 0;
            byte_pos = 0;
            n_timeouts = n_timeouts + 1;
          end
          if (!capturing && elapsed >= {16'd0, cfg_interval}) begin
            capturing = 1;
            byte_pos = 0;
            req_stamp = now_ticks;
            n_requests = n_requests + 1;
            r.accepted = 1'b1;
            r.tx_valid = 1'b1;
            r.tx_byte = CMD_BYTE;
          end
        end
      end
      FUNC_BYTE: begin
        if (capturing) begin
          frame_bytes[byte_pos] = w.rx_byte;
          byte_pos++;
          if (byte_pos >= FRAME_LEN) begin
            lat_last = elapsed;
            if (elapsed > lat_peak) lat_peak = elapsed;
            n_responses = n_responses + 1;
            capturing = 0;
            frame_held = 1;
            byte_pos = 0;
          end
        end
      end
      FUNC_READ: begin
        if (frame_held) begin
          frame_held = 0;
          pos = int'({frame_bytes[5][6:0], frame_bytes[4], frame_bytes[3]}) - int'(cfg_offset);
          // fold once
          if (pos >= 65536) pos = pos - 131072;
          if (pos < -65536) pos = pos + 131072;
          r.accepted = 1'b1;
          r.angle = pos[23:0];
        end
      end
    endcase
    r.frame_ready = frame_held;
    r.rx_busy = capturing;
    r.request_total = n_requests;
    r.response_total = n_responses;
    r.timeout_total = n_timeouts;
    r.last_latency_us = lat_last;
    r.max_latency_us = lat_peak;
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
  endtask

  task automatic check_result(input eqc_result_t got, input eqc_result_t want);
    if (got.accepted !== want.accepted)
      flag_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
    if (got.tx_valid !== want.tx_valid)
      flag_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
    if (got.tx_byte !== want.tx_byte)
      flag_mismatch("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
    if (got.angle !== want.angle)
      flag_mismatch("angle", 32'(unsigned'(got.angle)), 32'(unsigned'(want.angle)));
    if (got.frame_ready !== want.frame_ready)
      flag_mismatch("frame_ready", 32'(got.frame_ready), 32'(want.frame_ready));
    if (got.rx_busy !== want.rx_busy)
      flag_mismatch("rx_busy", 32'(got.rx_busy), 32'(want.rx_busy));
    if (got.request_total !== want.request_total)
      flag_mismatch("request_total", got.request_total, want.request_total);
    if (got.response_total !== want.response_total)
      flag_mismatch("response_total", got.response_total, want.response_total);
    if (got.timeout_total !== want.timeout_total)
      flag_mismatch("timeout_total", got.timeout_total, want.timeout_total);
    if (got.last_latency_us !== want.last_latency_us)
      flag_mismatch("last_latency_us", got.last_latency_us, want.last_latency_us);
    if (got.max_latency_us !== want.max_latency_us)
      flag_mismatch("max_latency_us", got.max_latency_us, want.max_latency_us);
  endtask

  always @(posedge clk) begin
    eqc_result_t predicted;
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        advance_encoder(req_if.data, predicted);
        status_due.push_back(pin_valid ? pin_value : predicted);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (status_due.size() == 0)
          flag_mismatch("unexpected word", rsp_if.data.request_total, 32'd0);
        else
          check_result(rsp_if.data, status_due.pop_front());
      end
    end
  end

  // receiver: random backpressure, plus one long hold-off on request
  initial begin
    int n;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_rsp) begin
        rsp_if.ready <= 1'b0;
        for (n = 0; n < 64; n++) @(negedge clk);
        stall_rsp = 0;
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic stim_row_t row(input logic [1:0] f, input logic [7:0] b,
                                    input bit pinned, input eqc_result_t want);
    stim_row_t s;
    s.word.func = f;
    s.word.rx_byte = b;
    s.pinned = pinned;
    s.want = want;
    return s;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input eqc_item_t w, input bit pinned, input eqc_result_t want);
    if (words_sent < 330) begin
      send_idle_pct = 18;
      recv_idle_pct = 73;
    end else if (words_sent < 660) begin
      send_idle_pct = 73;
      recv_idle_pct = 18;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while (!stall_rsp && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    pin_valid = pinned;
    pin_value = want;
    req_if.valid <= 1'b1;
    req_if.data <= w;
    do @(posedge clk); while (!req_if.ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic push_event(input logic [1:0] f, input logic [7:0] b);
    eqc_item_t w;
    w.func = f;
    w.rx_byte = b;
    send_word(w, 1'b0, '0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TIMEOUT:  cfg_timeout = value[15:0];
      REG_INTERVAL: cfg_interval = value[15:0];
      REG_OFFSET:   cfg_offset = value[16:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] t, input logic [15:0] i,
                                input logic [16:0] o);
    write_reg(REG_TIMEOUT, 32'(t));
    write_reg(REG_INTERVAL, 32'(i));
    write_reg(REG_OFFSET, 32'(o));
  endtask

  // drop valid, wait for every status word, then let the pipeline settle
  task automatic quiesce();
    req_if.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic poll_phase(input int quota);
    int stop_at;
    int nbytes;
    int k;
    stop_at = words_sent + quota;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 70) begin
        k = $urandom_range(0, (cfg_interval > 6) ? 6 : cfg_interval + 2);
        repeat (k) push_event(FUNC_TICK, 8'($urandom));
        push_event(FUNC_REQUEST, 8'($urandom));
        nbytes = ($urandom_range(9) == 0) ? $urandom_range(0, FRAME_LEN - 1) : FRAME_LEN;
        for (k = 0; k < nbytes; k++) begin
          if ($urandom_range(4) == 0) push_event(FUNC_TICK, 8'($urandom));
          push_event(FUNC_BYTE, pick_byte());
        end
        if ($urandom_range(6) == 0) push_event(FUNC_REQUEST, 8'($urandom));
        if ($urandom_range(6) != 0) push_event(FUNC_READ, 8'($urandom));
      end else if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(0, 70)) push_event(FUNC_TICK, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) push_event(2'($urandom), pick_byte());
      end
    end
  endtask

  initial begin
    eqc_result_t first_poll;
    eqc_result_t top_angle;
    int k;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    stall_rsp = 0;
    pin_valid = 0;
    pin_value = '0;
    mismatches = 0;
    words_sent = 0;
    send_idle_pct = 18;
    recv_idle_pct = 73;
    cfg_timeout = TIMEOUT_RST;
    cfg_interval = INTERVAL_RST;
    cfg_offset = OFFSET_RST;
    now_ticks = '0;
    req_stamp = '0;
    capturing = 0;
    frame_held = 0;
    byte_pos = 0;
    for (k = 0; k < FRAME_LEN; k++) frame_bytes[k] = '0;
    n_requests = '0;
    n_responses = '0;
    n_timeouts = '0;
    lat_last = '0;
    lat_peak = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    first_poll = '0;
    first_poll.accepted = 1'b1;
    first_poll.tx_valid = 1'b1;
    first_poll.tx_byte = CMD_BYTE;
    first_poll.rx_busy = 1'b1;
    first_poll.request_total = 32'd1;

    top_angle = '0;
    top_angle.accepted = 1'b1;
    top_angle.angle = 24'sd8257535;
    top_angle.request_total = 32'd1;
    top_angle.response_total = 32'd1;

    // reset defaults: empty read, early request, stray byte, tick
    plan.push_back(row(FUNC_READ, 8'h00, 1'b1, '0));
    plan.push_back(row(FUNC_REQUEST, 8'hFF, 1'b1, '0));
    plan.push_back(row(FUNC_BYTE, 8'hFF, 1'b1, '0));
    plan.push_back(row(FUNC_TICK, 8'h00, 1'b1, '0));
    // zero interval, timeout 5, zero offset: full-scale frame, pending and timed-out requests
    plan.push_back(row(FUNC_REQUEST, 8'h00, 1'b1, first_poll));
    for (k = 0; k < FRAME_LEN; k++)
      plan.push_back(row(FUNC_BYTE, (k >= 3 && k <= 5) ? 8'hFF : 8'(k * 37), 1'b0, '0));
    plan.push_back(row(FUNC_REQUEST, 8'h00, 1'b0, '0));
    plan.push_back(row(FUNC_READ, 8'h00, 1'b1, top_angle));
    plan.push_back(row(FUNC_REQUEST, 8'h00, 1'b0, '0));
    for (k = 0; k < 5; k++) plan.push_back(row(FUNC_TICK, 8'h00, 1'b0, '0));
    plan.push_back(row(FUNC_REQUEST, 8'h00, 1'b0, '0));

    for (k = 0; k < plan.size(); k++) begin
      if (k == 4) begin
        quiesce();
        apply_settings(16'd5, 16'd0, 17'd0);
      end
      send_word(plan[k].word, plan[k].pinned, plan[k].want);
    end

    quiesce();
    apply_settings(16'd3, 16'd0, 17'd131071);
    poll_phase(180);
    quiesce();
    apply_settings(16'd0, 16'd2, 17'd65536);
    poll_phase(180);
    quiesce();
    apply_settings(16'd65535, 16'd65535, 17'd0);
    poll_phase(40);
    quiesce();
    apply_settings(16'd40, 16'd8, 17'($urandom_range(0, 131071)));
    stall_rsp = 1;
    poll_phase(180);
    quiesce();
    apply_settings(16'($urandom_range(1, 60)), 16'($urandom_range(0, 10)),
                   17'($urandom_range(0, 131071)));
    poll_phase(180);
    quiesce();
    apply_settings(16'd1, 16'd1, OFFSET_RST);
    poll_phase(180);
    quiesce();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
